[design/tfb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfb_pkg
// shared constants and types for the tcp/ipv4 frame builder
// ---------------------------------------------------------------------------
package tfb_pkg;

	localparam int MaxPayload = 256;
	localparam int CntW = $clog2(MaxPayload + 1);
	localparam int AddrW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
	localparam int HdrBytes = 54;
	localparam int TotW = $clog2(HdrBytes + MaxPayload + 1);

	localparam logic [1:0] RegSrcAddr = 2'd0;
	localparam logic [1:0] RegDstAddr = 2'd1;
	localparam logic [1:0] RegSrcPort = 2'd2;
	localparam logic [1:0] RegDstPort = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SUM  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// sum of all 16-bit words, folded and complemented
	function automatic logic [15:0] fold_ck(input logic [31:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		b = {1'b0, a[15:0]} + {16'd0, a[16]};
		return ~(b[15:0] + {15'd0, b[16]});
	endfunction

endpackage

[design/tfb_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tfb_ram
// generic single-port ram with registered read
// ---------------------------------------------------------------------------
module tfb_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[design/tcp_ipv4_frame_builder_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcp_ipv4_frame_builder_unit
// collects payload bytes, then emits an ethernet/ipv4/tcp frame in 8-byte beats
// ---------------------------------------------------------------------------
// channel  | direction | handshake           | content
// item     | in        | start & !busy       | action, payload_byte
// result   | out       | strobe, no stall    | frame_word, valid_bytes, frame_end, truncated
// config   | in        | cfg_valid&cfg_ready | cfg_index, cfg_data
//
// an append leaves busy low, so appends run at one byte per cycle while idle
// a build first folds both checksums in ST_SUM, then ST_EMIT walks one frame
// byte per cycle, payload bytes read from the buffer ram and landing in the
// next cycle
// each beat strobes the cycle after its last byte lands
// reset clears count, sum, overflow flag and registers; the ram is not cleared
// the receiver cannot stall; strobe marks each beat for one cycle
module tcp_ipv4_frame_builder_unit
	import tfb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [7:0]  payload_byte,
	output logic        strobe,
	output logic [63:0] frame_word,
	output logic [3:0]  valid_bytes,
	output logic        frame_end,
	output logic        truncated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [31:0] src_addr_q, dst_addr_q;
	logic [15:0] src_port_q, dst_port_q;
	logic [CntW-1:0] count_q;
	logic [31:0] psum_q;
	logic        ovf_q;
	state_t      state_q;
	logic [15:0] ip_ck_q, tcp_ck_q;
	logic [31:0] hsum_q;
	logic [TotW-1:0] pos_q;      // frame byte of next byte to read
	logic [TotW-1:0] total_q;
	logic [63:0] word_q;
	logic [2:0]  bidx_q;         // byte slot being filled
	logic        rd_pend_q;      // ram read issued last cycle
	logic [2:0]  rd_slot_q;
	logic        fin_q;

	logic        ram_we;
	logic [AddrW-1:0] ram_addr;
	logic [7:0]  ram_rdata;
	logic        accept;
	logic [15:0] tcp_len, ip_len;
	logic [7:0]  hdr_byte;
	logic [TotW-1:0] pay_idx;

	assign accept = start && !busy;
	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign tcp_len = 16'(20 + count_q);
	assign ip_len = 16'(40 + count_q);
	assign pay_idx = pos_q - TotW'(HdrBytes);

	// buffer write on append, read while emitting payload
	assign ram_we = accept && !action && (count_q < CntW'(MaxPayload));
	assign ram_addr = ram_we ? count_q[AddrW-1:0] : pay_idx[AddrW-1:0];

	tfb_ram #(.Width(8), .Depth(MaxPayload)) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(payload_byte),
		.rdata(ram_rdata)
	);

	// header byte at frame position pos_q
	always_comb begin
		case (pos_q[5:0])
			6'd0, 6'd6: hdr_byte = 8'h02;
			6'd5: hdr_byte = 8'h02;
			6'd11: hdr_byte = 8'h01;
			6'd12: hdr_byte = 8'h08;
			6'd14: hdr_byte = 8'h45;
			6'd16: hdr_byte = ip_len[15:8];
			6'd17: hdr_byte = ip_len[7:0];
			6'd20: hdr_byte = 8'h40;
			6'd22: hdr_byte = 8'd64;
			6'd23: hdr_byte = 8'd6;
			6'd24: hdr_byte = ip_ck_q[15:8];
			6'd25: hdr_byte = ip_ck_q[7:0];
			6'd26: hdr_byte = src_addr_q[31:24];
			6'd27: hdr_byte = src_addr_q[23:16];
			6'd28: hdr_byte = src_addr_q[15:8];
			6'd29: hdr_byte = src_addr_q[7:0];
			6'd30: hdr_byte = dst_addr_q[31:24];
			6'd31: hdr_byte = dst_addr_q[23:16];
			6'd32: hdr_byte = dst_addr_q[15:8];
			6'd33: hdr_byte = dst_addr_q[7:0];
			6'd34: hdr_byte = src_port_q[15:8];
			6'd35: hdr_byte = src_port_q[7:0];
			6'd36: hdr_byte = dst_port_q[15:8];
			6'd37: hdr_byte = dst_port_q[7:0];
			6'd41, 6'd45: hdr_byte = 8'h01;
			6'd46: hdr_byte = 8'h50;
			6'd47: hdr_byte = 8'h18;
			6'd48, 6'd49: hdr_byte = 8'hFF;
			6'd50: hdr_byte = tcp_ck_q[15:8];
			6'd51: hdr_byte = tcp_ck_q[7:0];
			default: hdr_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_addr_q <= '0;
			dst_addr_q <= '0;
			src_port_q <= '0;
			dst_port_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegSrcAddr: src_addr_q <= cfg_data;
				RegDstAddr: dst_addr_q <= cfg_data;
				RegSrcPort: src_port_q <= cfg_data[15:0];
				RegDstPort: dst_port_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// the emit walk reads one byte per cycle: header bytes directly, payload
	// bytes through the ram (landing in the next cycle). a beat goes out when the
	// last slot of the word is filled or the frame ends.
	logic [63:0] word_n;
	logic        fill;
	logic [7:0]  fill_byte;
	logic        is_pay;

	always_comb begin
		is_pay = (pos_q >= TotW'(HdrBytes));
		fill = 1'b0;
		fill_byte = hdr_byte;
		if (rd_pend_q) begin
			fill = 1'b1;
			fill_byte = ram_rdata;
		end else if (state_q == ST_EMIT && !fin_q && !is_pay) begin
			fill = 1'b1;
		end
		word_n = word_q;
		if (fill) begin
			word_n[63 - 8*(rd_pend_q ? rd_slot_q : bidx_q) -: 8] = fill_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			psum_q <= '0;
			ovf_q <= 1'b0;
			strobe <= 1'b0;
			rd_pend_q <= 1'b0;
			fin_q <= 1'b0;
		end else begin
			strobe <= 1'b0;
			rd_pend_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !action) begin
						if (ram_we) begin
							count_q <= count_q + 1'b1;
							psum_q <= psum_q + (count_q[0] ? {24'd0, payload_byte}
								: {16'd0, payload_byte, 8'd0});
						end else begin
							ovf_q <= 1'b1;
						end
					end else if (accept) begin
						hsum_q <= 32'(src_addr_q[31:16]) + 32'(src_addr_q[15:0])
							+ 32'(dst_addr_q[31:16]) + 32'(dst_addr_q[15:0]);
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					// ip: 0x4500 + 0x4000 + 0x4006; tcp: 6 + seq 1 + ack 1 + 0x5018 + 0xffff
					ip_ck_q <= fold_ck(hsum_q + 32'(ip_len) + 32'h0000_C506);
					tcp_ck_q <= fold_ck(hsum_q + 32'(tcp_len) + 32'(src_port_q)
						+ 32'(dst_port_q) + 32'h0001_501F + psum_q);
					total_q <= TotW'(HdrBytes) + TotW'(count_q);
					pos_q <= '0;
					bidx_q <= '0;
					word_q <= '0;
					fin_q <= 1'b0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!fin_q) begin
						if (is_pay) begin
							rd_pend_q <= 1'b1;
							rd_slot_q <= bidx_q;
						end
						if (pos_q + 1'b1 == total_q) begin
							fin_q <= 1'b1;
						end
						pos_q <= pos_q + 1'b1;
						bidx_q <= bidx_q + 1'b1;
					end
					// beat complete once its last byte landed
					if (fill && ((rd_pend_q ? rd_slot_q : bidx_q) == 3'd7
						|| (fin_q || (!is_pay && pos_q + 1'b1 == total_q))
						&& !(!rd_pend_q && is_pay))) begin
						strobe <= 1'b1;
						frame_word <= word_n;
						valid_bytes <= {1'b0, rd_pend_q ? rd_slot_q : bidx_q} + 4'd1;
						frame_end <= fin_q || (!is_pay && pos_q + 1'b1 == total_q);
						truncated <= ovf_q;
						word_q <= '0;
						if (fin_q || (!is_pay && pos_q + 1'b1 == total_q)) begin
							state_q <= ST_IDLE;
							count_q <= '0;
							psum_q <= '0;
							ovf_q <= 1'b0;
						end
					end else begin
						word_q <= word_n;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(state_q) == ST_EMIT)
		else $error("beat outside emit");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxPayload))
		else $error("payload count overrun");
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && frame_end |-> state_q == ST_IDLE)
		else $error("frame end without return to idle");
`endif
endmodule
